// ----- rtl/core/relay_command_sequencer_assert.svh -----
// Assertion macros for the relay command sequencer.
// RCS_ASSERT checks a property at every clock edge outside reset.
// RCS_ASSERT_IMPL checks that the antecedent implies the consequent in the same cycle.
// RCS_ASSERT_NEXT checks that the antecedent implies the consequent in the next cycle.
`ifndef RELAY_COMMAND_SEQUENCER_ASSERT_SVH
`define RELAY_COMMAND_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

`define RCS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define RCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RCS_ASSERT(label, clk, rst_n, prop, msg)

`define RCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/rcs_pkg.sv -----
`default_nettype none

package rcs_pkg;

  // Byte position counter; saturates at its all-ones value.
  localparam int unsigned IDX_W   = 7;
  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SKIP = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RUN  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_OPLO = 3'd3;
  localparam logic [PHASE_W-1:0] PH_OPHI = 3'd4;

  localparam logic [1:0] REQ_START_ON  = 2'd0;
  localparam logic [1:0] REQ_START_OFF = 2'd1;
  localparam logic [1:0] REQ_BYTE      = 2'd2;

  localparam logic [7:0] END_MARK        = 8'hFF;
  localparam logic [7:0] OP_WAIT_TENTHS  = 8'd8;
  localparam logic [7:0] OP_WAIT_SECONDS = 8'd9;

  localparam logic [1:0] WU_NONE    = 2'd0;
  localparam logic [1:0] WU_TENTHS  = 2'd1;
  localparam logic [1:0] WU_SECONDS = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SKIPPED = 2'd1;
  localparam logic [1:0] ST_ENDED   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_SWITCH_WAIT = 1'b0;  // word index, paddr[2]
  localparam logic [7:0]  SWITCH_WAIT_RESET = 8'd1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] table_byte;
  } req_t;

  typedef struct packed {
    logic [3:0]  relay_bits;
    logic [15:0] wait_amount;
    logic [1:0]  wait_unit;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic [3:0]         relay_reg;
    logic [PHASE_W-1:0] phase;
    logic [IDX_W-1:0]   byte_index;
    logic [7:0]         operand_low;
  } seq_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/rcs_req_if.sv -----
`default_nettype none

interface rcs_req_if;
  logic          valid;
  logic          ready;
  rcs_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rcs_res_if.sv -----
`default_nettype none

interface rcs_res_if;
  logic          valid;
  logic          ready;
  rcs_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rcs_apb_regs.sv -----
`default_nettype none

module rcs_apb_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rcs_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rcs_pkg::PDATA_W-1:0] pwdata,
  output logic      [rcs_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output logic      [7:0]                  switch_wait_tenths_o
);

  logic       sel_wait;
  logic       wr_en;
  logic [7:0] wait_tenths_q;
  logic [7:0] wait_tenths_d;

  // Word index only; byte offset bits are don't-care.
  assign sel_wait = (paddr[2] == rcs_pkg::REG_SWITCH_WAIT);
  assign wr_en    = psel && penable && pwrite;
  assign pready   = 1'b1;

  assign wait_tenths_d = (wr_en && sel_wait) ? pwdata[7:0] : wait_tenths_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_tenths_q <= rcs_pkg::SWITCH_WAIT_RESET;
    end else begin
      wait_tenths_q <= wait_tenths_d;
    end
  end

  assign prdata = sel_wait ? {{(rcs_pkg::PDATA_W-8){1'b0}}, wait_tenths_q}
                           : '0;

  assign switch_wait_tenths_o = wait_tenths_q;

endmodule

`default_nettype wire

// ----- rtl/core/rcs_decoder.sv -----
`default_nettype none

module rcs_decoder #(
  parameter int unsigned TABLE_LEN = 96
) (
  input  rcs_pkg::seq_state_t state_i,
  input  rcs_pkg::req_t       item_i,
  input  wire logic [7:0]     switch_wait_tenths_i,
  output rcs_pkg::seq_state_t state_o,
  output rcs_pkg::res_t       res_o
);

  logic [rcs_pkg::IDX_W-1:0] idx_adv;
  logic                      at_end;
  logic [7:0]                b;
  logic [3:0]                mask;

  assign b       = item_i.table_byte;
  assign idx_adv = (state_i.byte_index == rcs_pkg::IDX_MAX) ? state_i.byte_index
                 : state_i.byte_index + rcs_pkg::IDX_W'(1);
  assign at_end  = (idx_adv >= rcs_pkg::IDX_W'(TABLE_LEN));
  assign mask    = 4'b0001 << b[2:1];

  always_comb begin
    state_o           = state_i;
    res_o.wait_amount = '0;
    res_o.wait_unit   = rcs_pkg::WU_NONE;
    res_o.status      = rcs_pkg::ST_IGNORED;

    case (item_i.req_type)
      rcs_pkg::REQ_START_ON: begin
        state_o.phase      = rcs_pkg::PH_RUN;
        state_o.byte_index = '0;
        res_o.status       = rcs_pkg::ST_OK;
      end
      rcs_pkg::REQ_START_OFF: begin
        state_o.phase      = rcs_pkg::PH_SKIP;
        state_o.byte_index = '0;
        res_o.status       = rcs_pkg::ST_OK;
      end
      rcs_pkg::REQ_BYTE: begin
        case (state_i.phase)
          rcs_pkg::PH_SKIP: begin
            state_o.byte_index = idx_adv;
            res_o.status       = rcs_pkg::ST_SKIPPED;
            if (b == rcs_pkg::END_MARK) begin
              state_o.phase = rcs_pkg::PH_RUN;
            end
            if (at_end) begin
              state_o.phase = rcs_pkg::PH_IDLE;
            end
          end
          rcs_pkg::PH_RUN: begin
            if (b[7:3] == 5'd0) begin
              // Even opcode sets the relay, odd clears it.
              state_o.relay_reg  = b[0] ? (state_i.relay_reg & ~mask)
                                        : (state_i.relay_reg | mask);
              state_o.byte_index = idx_adv;
              res_o.status       = rcs_pkg::ST_OK;
              if (at_end) begin
                state_o.phase = rcs_pkg::PH_IDLE;
              end
            end else if (b == rcs_pkg::OP_WAIT_TENTHS) begin
              res_o.wait_amount  = {8'd0, switch_wait_tenths_i};
              res_o.wait_unit    = rcs_pkg::WU_TENTHS;
              state_o.byte_index = idx_adv;
              res_o.status       = rcs_pkg::ST_OK;
              if (at_end) begin
                state_o.phase = rcs_pkg::PH_IDLE;
              end
            end else if (b == rcs_pkg::OP_WAIT_SECONDS) begin
              state_o.byte_index = idx_adv;
              state_o.phase      = rcs_pkg::PH_OPLO;
              res_o.status       = rcs_pkg::ST_OK;
            end else begin
              state_o.phase = rcs_pkg::PH_IDLE;
              res_o.status  = rcs_pkg::ST_ENDED;
            end
          end
          rcs_pkg::PH_OPLO: begin
            state_o.operand_low = b;
            state_o.byte_index  = idx_adv;
            state_o.phase       = rcs_pkg::PH_OPHI;
            res_o.status        = rcs_pkg::ST_OK;
          end
          rcs_pkg::PH_OPHI: begin
            // Operand bytes are always taken; check the length only now.
            res_o.wait_amount  = {b, state_i.operand_low};
            res_o.wait_unit    = rcs_pkg::WU_SECONDS;
            state_o.byte_index = idx_adv;
            state_o.phase      = at_end ? rcs_pkg::PH_IDLE : rcs_pkg::PH_RUN;
            res_o.status       = rcs_pkg::ST_OK;
          end
          default: begin
            res_o.status = rcs_pkg::ST_IGNORED;
          end
        endcase
      end
      default: begin
        res_o.status = rcs_pkg::ST_IGNORED;
      end
    endcase

    res_o.relay_bits = state_o.relay_reg;
  end

endmodule

`default_nettype wire

// ----- rtl/core/relay_command_sequencer.sv -----
// Relay command sequencer.
// Request channel (req_i): one beat per start request or table byte. A start
// beat opens the on-sequence or the off-sequence; byte beats then run the
// command table, one byte per beat.
// Result channel (res_o): exactly one beat per request beat, in order, with
// the relay state, any requested wait and a status code.
// Configuration: APB port, register 0 at address 0 holds the wait in tenths
// of a second for the relay wait opcode (reset value 1).
// Path: a request beat accepted into the input register is decoded into the
// result register, which drives the result channel.
// Throughput: one beat per cycle while the receiver holds ready high, with a
// combinational decode between the two registers.
// Reset: all relays off, sequencer idle, both registers empty.
// Stall: when the receiver holds ready low, the result register holds and the
// input register still takes one more beat if empty; ready then drops until the
// result is taken.
`default_nettype none

`include "relay_command_sequencer_assert.svh"

module relay_command_sequencer #(
  parameter int unsigned TABLE_LEN = 96
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  rcs_req_if.sink                          req_i,
  rcs_res_if.source                        res_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rcs_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rcs_pkg::PDATA_W-1:0] pwdata,
  output logic      [rcs_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);

  logic [7:0] switch_wait_tenths;

  logic                in_valid_q;
  logic                in_valid_d;
  rcs_pkg::req_t       in_item_q;
  rcs_pkg::seq_state_t state_q;
  rcs_pkg::seq_state_t state_d;
  rcs_pkg::seq_state_t state_nxt;
  rcs_pkg::res_t       dec_res;
  logic                out_valid_q;
  logic                out_valid_d;
  rcs_pkg::res_t       out_res_q;
  logic                stage_adv;
  logic                stage_fire;
  logic                in_fire;

  rcs_apb_regs u_regs (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .switch_wait_tenths_o (switch_wait_tenths)
  );

  rcs_decoder #(
    .TABLE_LEN (TABLE_LEN)
  ) u_dec (
    .state_i              (state_q),
    .item_i               (in_item_q),
    .switch_wait_tenths_i (switch_wait_tenths),
    .state_o              (state_nxt),
    .res_o                (dec_res)
  );

  // Advance the input stage whenever the result register is free or drains.
  assign stage_adv   = !out_valid_q || res_o.ready;
  assign stage_fire  = in_valid_q && stage_adv;
  assign req_i.ready = !in_valid_q || stage_adv;
  assign in_fire     = req_i.valid && req_i.ready;

  assign in_valid_d  = in_fire ? 1'b1 : (stage_fire ? 1'b0 : in_valid_q);
  assign out_valid_d = stage_fire ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);
  assign state_d     = stage_fire ? state_nxt : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{relay_reg: 4'd0, phase: rcs_pkg::PH_IDLE,
                       byte_index: '0, operand_low: 8'd0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= req_i.payload;
    end
    if (stage_fire) begin
      out_res_q <= dec_res;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_res_q;

  `RCS_ASSERT_NEXT(a_fire_fills_out, clk_i, rst_ni, stage_fire, out_valid_q,
                   "decoded beat did not reach the result register")
  `RCS_ASSERT_NEXT(a_relay_hold, clk_i, rst_ni, !stage_fire, $stable(state_q.relay_reg),
                   "relay state changed without a decoded beat")
  `RCS_ASSERT_IMPL(a_no_wait_zero, clk_i, rst_ni,
                   out_valid_q && (out_res_q.wait_unit == rcs_pkg::WU_NONE),
                   out_res_q.wait_amount == 16'd0,
                   "wait amount set without a wait unit")

endmodule

`default_nettype wire
